>>> sv/rqws_pkg.sv
package rqws_pkg;
    localparam int KIND_W = 2;
    localparam int END_W  = 13;
    localparam int EV_W   = 3;
    localparam int POS_W  = 12;
    localparam int QI_W   = 8;
    localparam int BW_W   = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_SORT = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [EV_W-1:0] {
        EV_EXPAND_L  = 3'd0,
        EV_EXPAND_R  = 3'd1,
        EV_SHRINK_L  = 3'd2,
        EV_SHRINK_R  = 3'd3,
        EV_READY     = 3'd4,
        EV_EXHAUSTED = 3'd5
    } event_t;

    // one stored query with its sort key
    typedef struct packed {
        logic [END_W-1:0] left_end;
        logic [END_W-1:0] right_end;
        logic [END_W-1:0] bucket;
        logic [11:0]      index;
    } query_t;

    function automatic logic [END_W-1:0] sat_end(input logic [END_W-1:0] v,
                                                 input logic [END_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction
endpackage

>>> sv/range_query_window_scheduler_unit.sv
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: left_end[12:0], right_end[25:13]; tuser: kind[1:0]
// m_axis  | out | tdata: position[11:0], query_index[19:12]; tuser: event_res[2:0]
// cfg     | in  | block_width[12:0]
// A tick result is registered and shows the cycle after its transaction. Sort
// holds s_axis_tready low through 13 divide steps for the bucket of every cell,
// MAX_QUERIES+1 odd-even rounds, a copy into the served list, then a skip over
// served entries. Synchronous active-low reset empties the chain.
// A stalled result blocks new transactions until the output register frees.
module range_query_window_scheduler_unit #(
    parameter int MAX_QUERIES   = 256,
    parameter int MAX_POSITIONS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,         // block_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,      // left_end, right_end
    input  logic [7:0]  s_axis_tuser,      // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,      // position, query_index
    output logic [7:0]  m_axis_tuser       // event_res
);
    import rqws_pkg::*;

    localparam int N = MAX_QUERIES;
    localparam int CW = $clog2(N + 1);
    localparam int SW = $clog2(N + END_W + 2);
    localparam logic [END_W-1:0] PLIM = END_W'(MAX_POSITIONS);

    typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_SORT, ST_SKIP} state_t;

    state_t state_reg;
    logic [BW_W-1:0] bw_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] skip_reg;
    logic [SW-1:0] sort_cnt_reg;
    logic [END_W-1:0] wl_reg, wr_reg;
    logic active_reg;
    query_t cur_reg;
    logic ovalid_reg;
    logic [EV_W-1:0] oev_reg;
    logic [POS_W-1:0] opos_reg;
    logic [QI_W-1:0] oqi_reg;

    // load chain (in add order) and served chain (sorted)
    query_t lq [N];
    logic   lv [N];
    query_t sq [N];
    logic   sv_q [N];

    logic   accept;
    kind_t  kind;
    logic [END_W-1:0] in_l, in_r, bwd;
    query_t new_q;

    assign s_axis_tready = (state_reg == ST_RUN) && !(ovalid_reg && !m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign kind = kind_t'(s_axis_tuser[1:0]);
    assign in_l = sat_end(s_axis_tdata[12:0], PLIM);
    assign in_r = sat_end(s_axis_tdata[25:13], PLIM);
    assign bwd  = (bw_reg == '0) ? END_W'(1) : bw_reg;

    // bucket holds the left end until the divide pass of a sort
    always_comb begin
        new_q.left_end  = in_l;
        new_q.right_end = in_r;
        new_q.bucket    = in_l;
        new_q.index     = 12'(count_reg);
    end

    logic do_add, do_sort_start, do_tick, sorting, sort_done, dividing, skipping;
    assign do_add = accept && kind == KIND_ADD && count_reg < CW'(N);
    assign do_sort_start = accept && kind == KIND_SORT;
    assign do_tick = accept && kind == KIND_TICK;
    assign dividing = state_reg == ST_DIV;
    assign sorting = state_reg == ST_SORT;
    assign sort_done = sorting && sort_cnt_reg == SW'(N + 1);
    assign skipping = (state_reg == ST_SKIP) && (skip_reg != '0);

    // working copy: a chain of cells that sorts in place
    query_t wq [N];
    logic   wv [N];
    logic   take_next;
    assign take_next = do_tick && !active_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cells
            logic lo;
            // exchange pair (g,g+1) when parity of g differs from round parity
            assign lo = 1'(g % 2) != sort_cnt_reg[0];
            rqws_cell u_load (
                .aclk(aclk), .aresetn(aresetn),
                .load_en(do_add && count_reg == CW'(g)),
                .load_in(new_q), .valid_in(1'b1),
                .shift_en(1'b0), .shift_in(new_q), .shift_valid_in(1'b0),
                .div_en(1'b0), .dvs(bwd),
                .swap_en(1'b0), .swap_lo(1'b0), .nbr(new_q), .nbr_valid(1'b0),
                .q(lq[g]), .q_valid(lv[g])
            );
            rqws_cell u_work (
                .aclk(aclk), .aresetn(aresetn),
                .load_en(do_sort_start), .load_in(lq[g]), .valid_in(lv[g]),
                .shift_en(1'b0), .shift_in(lq[g]), .shift_valid_in(1'b0),
                .div_en(dividing), .dvs(bwd),
                .swap_en(sorting && !sort_done),
                .swap_lo(lo),
                .nbr(lo ? ((g + 1 < N) ? wq[(g + 1) % N] : wq[g])
                        : ((g > 0) ? wq[(g + N - 1) % N] : wq[g])),
                .nbr_valid(lo ? ((g + 1 < N) ? wv[(g + 1) % N] : 1'b0)
                              : ((g > 0) ? wv[(g + N - 1) % N] : 1'b0)),
                .q(wq[g]), .q_valid(wv[g])
            );
            rqws_cell u_serve (
                .aclk(aclk), .aresetn(aresetn),
                .load_en(sort_done), .load_in(wq[g]), .valid_in(wv[g]),
                .shift_en(take_next || skipping),
                .shift_in((g + 1 < N) ? sq[(g + 1) % N] : sq[g]),
                .shift_valid_in((g + 1 < N) ? sv_q[(g + 1) % N] : 1'b0),
                .div_en(1'b0), .dvs(bwd),
                .swap_en(1'b0), .swap_lo(1'b0), .nbr(wq[g]), .nbr_valid(1'b0),
                .q(sq[g]), .q_valid(sv_q[g])
            );
        end
    endgenerate

    // window step
    query_t q_use;
    logic   have;
    assign q_use = active_reg ? cur_reg : sq[0];
    assign have  = active_reg || sv_q[0];

    logic [EV_W-1:0] ev_n;
    logic [POS_W-1:0] pos_n;
    logic [END_W-1:0] wl_n, wr_n;
    logic act_n;
    always_comb begin
        ev_n = EV_READY; pos_n = '0; wl_n = wl_reg; wr_n = wr_reg; act_n = 1'b1;
        if (!have) begin
            ev_n = EV_EXHAUSTED; act_n = 1'b0;
        end else if (wl_reg > q_use.left_end) begin
            wl_n = wl_reg - 1'b1; ev_n = EV_EXPAND_L; pos_n = POS_W'(wl_n);
        end else if (wr_reg < q_use.right_end) begin
            wr_n = wr_reg + 1'b1; ev_n = EV_EXPAND_R; pos_n = POS_W'(wr_reg);
        end else if (wl_reg < q_use.left_end) begin
            wl_n = wl_reg + 1'b1; ev_n = EV_SHRINK_L; pos_n = POS_W'(wl_reg);
        end else if (wr_reg > q_use.right_end) begin
            wr_n = wr_reg - 1'b1; ev_n = EV_SHRINK_R; pos_n = POS_W'(wr_n);
        end else begin
            act_n = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            bw_reg <= BW_W'(64);
            count_reg <= '0;
            sp_reg <= '0;
            skip_reg <= '0;
            sort_cnt_reg <= '0;
            wl_reg <= '0;
            wr_reg <= '0;
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_we) bw_reg <= cfg_wdata;
            if (do_add) count_reg <= count_reg + 1'b1;
            if (take_next && sv_q[0]) sp_reg <= sp_reg + 1'b1;
            unique case (state_reg)
                ST_RUN: begin
                    if (do_sort_start) begin
                        state_reg <= ST_DIV;
                        sort_cnt_reg <= '0;
                    end
                end
                ST_DIV: begin
                    if (sort_cnt_reg == SW'(END_W - 1)) begin
                        state_reg <= ST_SORT;
                        sort_cnt_reg <= '0;
                    end else begin
                        sort_cnt_reg <= sort_cnt_reg + 1'b1;
                    end
                end
                ST_SORT: begin
                    sort_cnt_reg <= sort_cnt_reg + 1'b1;
                    if (sort_done) begin
                        state_reg <= ST_SKIP;
                        skip_reg <= sp_reg;
                    end
                end
                ST_SKIP: begin
                    if (skip_reg == '0) state_reg <= ST_RUN;
                    else skip_reg <= skip_reg - 1'b1;
                end
            endcase
            ovalid_reg <= do_tick || (ovalid_reg && !m_axis_tready);
            if (do_tick) begin
                wl_reg <= wl_n;
                wr_reg <= wr_n;
                active_reg <= act_n;
            end
        end
        if (take_next) cur_reg <= sq[0];
        if (do_tick) begin
            oev_reg <= ev_n;
            opos_reg <= pos_n;
            oqi_reg <= (ev_n == EV_READY) ? QI_W'(q_use.index) : '0;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, oqi_reg, opos_reg};
    assign m_axis_tuser  = {5'd0, oev_reg};

`ifndef ASSERT_OFF
    a_no_take_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !s_axis_tready)
        else $error("input taken during sort");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_tick && ev_n == EV_READY) |=> !active_reg)
        else $error("query still active after ready");
`endif
endmodule

>>> sv/rqws_cell.sv
// One cell of the sorting chain. During load the cell takes the new entry from load_in;
// during divide the bucket field turns from left end into
// left end / block width, one quotient bit per cycle; during sort odd/even
// compare-exchange with the neighbor; during serve the chain shifts toward the head.
module rqws_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load_en,
    input  rqws_pkg::query_t load_in,
    input  logic            valid_in,
    input  logic            shift_en,
    input  rqws_pkg::query_t shift_in,
    input  logic            shift_valid_in,
    input  logic            div_en,
    input  logic [rqws_pkg::END_W-1:0] dvs,
    input  logic            swap_en,
    input  logic            swap_lo,
    input  rqws_pkg::query_t nbr,
    input  logic            nbr_valid,
    output rqws_pkg::query_t q,
    output logic            q_valid
);
    import rqws_pkg::*;

    query_t q_reg, q_next;
    logic   valid_reg, valid_next;
    logic [END_W-1:0] rem_reg, rem_next;
    logic [END_W:0]   part;

    function automatic logic goes_first(input query_t a, input query_t b);
        if (a.bucket != b.bucket) return a.left_end < b.left_end;
        if (a.right_end == b.right_end) begin
            if (a.left_end != b.left_end) return a.left_end < b.left_end;
            return a.index < b.index;
        end
        return (a.right_end < b.right_end) != a.bucket[0];
    endfunction

    logic nbr_first;
    assign nbr_first = swap_lo ? (nbr_valid && valid_reg && goes_first(nbr, q_reg))
                               : (nbr_valid && valid_reg && goes_first(q_reg, nbr));

    // restoring divide step: dividend bits leave the top of bucket, quotient enters below
    assign part = {rem_reg, q_reg.bucket[END_W-1]};

    always_comb begin
        q_next = q_reg;
        valid_next = valid_reg;
        rem_next = rem_reg;
        if (load_en) begin
            q_next = load_in;
            valid_next = valid_in;
            rem_next = '0;
        end else if (shift_en) begin
            q_next = shift_in;
            valid_next = shift_valid_in;
        end else if (div_en) begin
            if (part >= {1'b0, dvs}) begin
                rem_next = END_W'(part - {1'b0, dvs});
                q_next.bucket = {q_reg.bucket[END_W-2:0], 1'b1};
            end else begin
                rem_next = part[END_W-1:0];
                q_next.bucket = {q_reg.bucket[END_W-2:0], 1'b0};
            end
        end else if (swap_en && nbr_first) begin
            q_next = nbr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    assign q = q_reg;
    assign q_valid = valid_reg;
endmodule
